// ----- hw/rtl/shabs_pkg.sv -----
// Package: shared types, constants and round functions of the SHA-256 byte-stream hasher.
`default_nettype none

package shabs_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_APPEND      = 2'd0;
    localparam logic [1:0] MODE_FINISH_BYTE = 2'd1;
    localparam logic [1:0] MODE_FINISH      = 2'd2;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    // Initial chaining value, index 0 is the first digest word
    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic push;    // shift one byte into the block window
        logic load;    // copy chaining words into the working variables
        logic round;   // run one compression round
        logic update;  // fold working variables into the chaining words
        logic init;    // restore the initial chaining value
    } core_ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        case (r)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/shabs_core.sv -----
// Round unit: block window, message schedule, working variables and chaining words.
`default_nettype none

module shabs_core
    import shabs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire core_ctrl_t  ctrl,
    input  wire logic [7:0]  push_byte,
    input  wire logic [5:0]  round_idx,
    input  wire logic [2:0]  word_sel,
    output logic [31:0]      digest_word
);

    // win_reg[15] holds the oldest word of the window
    logic [15:0][31:0] win_reg, win_next;
    logic [7:0][31:0]  v_reg, v_next;
    logic [7:0][31:0]  ch_reg, ch_next;
    logic [511:0]      win_flat;
    logic [31:0]       w_cur, w_new, t1, t2;

    assign win_flat = win_reg;
    assign w_cur    = win_reg[15];
    assign w_new    = small_sigma1(win_reg[1]) + win_reg[6]
                    + small_sigma0(win_reg[14]) + win_reg[15];
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(round_idx) + w_cur;
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        win_next = win_reg;
        if (ctrl.push) begin
            win_next = {win_flat[503:0], push_byte};
        end else if (ctrl.round) begin
            win_next = {win_flat[479:0], w_new};
        end
    end

    always_comb begin
        v_next = v_reg;
        if (ctrl.load) begin
            v_next = ch_reg;
        end else if (ctrl.round) begin
            v_next[0] = t1 + t2;
            v_next[1] = v_reg[0];
            v_next[2] = v_reg[1];
            v_next[3] = v_reg[2];
            v_next[4] = v_reg[3] + t1;
            v_next[5] = v_reg[4];
            v_next[6] = v_reg[5];
            v_next[7] = v_reg[6];
        end
    end

    always_comb begin
        ch_next = ch_reg;
        if (ctrl.init) begin
            ch_next = INIT_HASH;
        end else if (ctrl.update) begin
            for (int j = 0; j < 8; j++) begin
                ch_next[j] = ch_reg[j] + v_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= INIT_HASH;
        end else begin
            ch_reg <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    assign digest_word = ch_reg[word_sel];

endmodule

`default_nettype wire

// ----- hw/rtl/sha256_byte_stream_hasher.sv -----
// Top level: byte intake, padding sequencer and digest output of the SHA-256 hasher.
// Intake: a plain byte that does not fill a block leaves s_ready high; a byte that fills
//   the 64-byte block starts a load, 64 rounds and an update before s_ready returns.
// Rounds run one per cycle; no new byte is taken while a block is being compressed.
// Finish: one pad byte per cycle up to the block end, one or two compressions, then
//   8 digest beats at one per cycle while m_ready is high.
// Reset: aresetn synchronous, active low; restores the initial chaining value and clears
//   the byte and bit counters. No clearing pass is needed.
`default_nettype none

module sha256_byte_stream_hasher
    import shabs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_message_byte,
    input  wire logic [1:0]  s_mode,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bits_reg, bits_next;
    logic        finish_reg, finish_next;
    logic        sent80_reg, sent80_next;
    logic        pad_done_reg, pad_done_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    core_ctrl_t  ctrl;
    logic [7:0]  push_byte;
    logic [5:0]  len_shift;
    logic [63:0] len_word;
    logic        is_finish;

    // Length bytes go out most significant first
    assign len_shift = {~len_idx_reg, 3'b000};
    assign len_word  = bits_reg >> len_shift;
    assign is_finish = (s_mode == MODE_FINISH_BYTE) || (s_mode == MODE_FINISH);

    always_comb begin
        state_next    = state_reg;
        bytes_next    = bytes_reg;
        bits_next     = bits_reg;
        finish_next   = finish_reg;
        sent80_next   = sent80_reg;
        pad_done_next = pad_done_reg;
        len_idx_next  = len_idx_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        ctrl          = '0;
        push_byte     = s_message_byte;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    finish_next   = is_finish;
                    sent80_next   = 1'b0;
                    pad_done_next = 1'b0;
                    len_idx_next  = 3'd0;
                    if (s_mode != MODE_FINISH) begin
                        ctrl.push  = 1'b1;
                        bytes_next = bytes_reg + 6'd1;
                        bits_next  = bits_reg + BITS_PER_BYTE;
                    end
                    if (ctrl.push && bytes_reg == LAST_BYTE_POS) begin
                        // block full: start a compression
                        ctrl.load  = 1'b1;
                        round_next = 6'd0;
                        state_next = ST_ROUND;
                    end else if (is_finish) begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                ctrl.push  = 1'b1;
                bytes_next = bytes_reg + 6'd1;
                if (!sent80_reg) begin
                    push_byte   = PAD_BYTE;
                    sent80_next = 1'b1;
                end else if (bytes_reg == LEN_FIELD_POS || len_idx_reg != 3'd0) begin
                    // length field: eight bytes, once started always run to the end
                    push_byte    = len_word[7:0];
                    len_idx_next = len_idx_reg + 3'd1;
                    if (len_idx_reg == LAST_WORD_IDX) begin
                        pad_done_next = 1'b1;
                    end
                end else begin
                    push_byte = 8'h00;
                end
                if (bytes_reg == LAST_BYTE_POS) begin
                    ctrl.load  = 1'b1;
                    round_next = 6'd0;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND: begin
                ctrl.round = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                ctrl.update = 1'b1;
                if (!finish_reg) begin
                    state_next = ST_IDLE;
                end else if (pad_done_reg) begin
                    out_idx_next = 3'd0;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end

            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD_IDX) begin
                        // digest delivered: start a fresh message
                        ctrl.init   = 1'b1;
                        bytes_next  = 6'd0;
                        bits_next   = 64'd0;
                        finish_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bytes_reg    <= 6'd0;
            bits_reg     <= 64'd0;
            finish_reg   <= 1'b0;
            sent80_reg   <= 1'b0;
            pad_done_reg <= 1'b0;
            len_idx_reg  <= 3'd0;
            round_reg    <= 6'd0;
            out_idx_reg  <= 3'd0;
        end else begin
            state_reg    <= state_next;
            bytes_reg    <= bytes_next;
            bits_reg     <= bits_next;
            finish_reg   <= finish_next;
            sent80_reg   <= sent80_next;
            pad_done_reg <= pad_done_next;
            len_idx_reg  <= len_idx_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    shabs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .push_byte   (push_byte),
        .round_idx   (round_reg),
        .word_sel    (out_idx_reg),
        .digest_word (m_digest_word)
    );

    // Outputs come straight from registers: hold them while a beat is stalled
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = out_idx_reg;
    assign m_last_word  = (out_idx_reg == LAST_WORD_IDX);

endmodule

`default_nettype wire

// ----- hw/rtl/shabs_checker.sv -----
// Checker: port-level assertions for the SHA-256 hasher, bound to the top level.
`default_nettype none

module shabs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_digest_word,
    input wire logic [2:0]  m_word_index,
    input wire logic        m_last_word
);

    // Stalled beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("stalled digest beat changed");

    // Intake and digest output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest pending");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
        else $error("last_word flag mismatch");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && (m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest word index did not advance");

    a_end_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> !m_valid && s_ready)
        else $error("digest burst did not end after last word");

endmodule

bind sha256_byte_stream_hasher shabs_checker u_shabs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the SHA-256 byte-stream hasher: directed and random messages.
`timescale 1ns / 1ps

module tb_top;
    import shabs_pkg::*;

    // Unused mode code; the block treats it as a plain append
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 150;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_AT_WORDS = 60;
    localparam int SETTLE_CYCLES = 100;

    // Well-known digests: the empty message and "abc"
    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // One row of the directed table; typed rows carry a known digest
    typedef struct packed {
        logic [7:0]   msg_byte;
        logic [1:0]   mode;
        logic         typed;
        logic [255:0] digest;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 12;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty message; the byte field is ignored on a bare finish
        '{8'ha5, MODE_FINISH,      1'b1, DIGEST_EMPTY},
        // "abc", with the middle byte sent on the spare mode code
        '{8'h61, MODE_APPEND,      1'b0, 256'd0},
        '{8'h62, MODE_SPARE,       1'b0, 256'd0},
        '{8'h63, MODE_FINISH_BYTE, 1'b1, DIGEST_ABC},
        // single-byte messages at both byte extremes
        '{8'h00, MODE_FINISH_BYTE, 1'b0, 256'd0},
        '{8'hff, MODE_FINISH_BYTE, 1'b0, 256'd0},
        // back-to-back empty message: the state must have been restored
        '{8'h00, MODE_FINISH,      1'b1, DIGEST_EMPTY},
        '{8'hff, MODE_APPEND,      1'b0, 256'd0},
        '{8'h00, MODE_SPARE,       1'b0, 256'd0},
        '{8'h5a, MODE_FINISH,      1'b0, 256'd0},
        '{8'hff, MODE_SPARE,       1'b0, 256'd0},
        '{8'h80, MODE_FINISH_BYTE, 1'b0, 256'd0}
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // DUT ports; every input starts at a known value
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_message_byte = 8'd0;
    logic [1:0]  s_mode = MODE_APPEND;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha256_byte_stream_hasher dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_mode         (s_mode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word)
    );

    // Hash predictor state: chaining words, partial block, bit length
    logic [31:0] chain_h [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] bit_len;

    digest_beat_t digest_beats_q [$];

    int mismatches = 0;
    int words_seen = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int items_sent = 0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sha256_byte_stream_hasher test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    task automatic hash_restart();
        for (int j = 0; j < 8; j++) chain_h[j] = SHA_IV[j];
        block_fill = 0;
        bit_len = 64'd0;
    endtask

    // Run the 64 rounds over the buffered block and fold into the chain
    task automatic hash_compress();
        logic [31:0] wv [8];
        logic [31:0] sched [16];
        logic [31:0] w, t1, t2, x15, x2;
        for (int j = 0; j < 8; j++) wv[j] = chain_h[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
            end else begin
                x15 = sched[(r - 15) % 16];
                x2  = sched[(r - 2) % 16];
                w = sched[r % 16] + sched[(r - 7) % 16]
                    + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
                    + (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10));
            end
            sched[r % 16] = w;
            t1 = wv[7] + (rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + SHA_K[r] + w;
            t2 = (rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            for (int j = 7; j > 0; j--) wv[j] = wv[j-1];
            wv[4] = wv[4] + t1;
            wv[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + wv[j];
    endtask

    task automatic hash_push(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill = (block_fill + 1) % 64;
        if (block_fill == 0) hash_compress();
    endtask

    // Absorb one accepted beat; on a finish, pad, close and hand back the digest
    task automatic hash_absorb(input logic [7:0] b, input logic [1:0] m,
                               output bit done, output logic [7:0][31:0] dig);
        logic [63:0] len;
        done = 1'b0;
        dig = '0;
        if (m != MODE_FINISH) begin
            hash_push(b);
            bit_len = bit_len + 64'd8;
        end
        if (m == MODE_FINISH || m == MODE_FINISH_BYTE) begin
            len = bit_len;
            hash_push(8'h80);
            while (block_fill != 56) hash_push(8'h00);
            for (int i = 0; i < 8; i++) hash_push(len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) dig[i] = chain_h[i];
            done = 1'b1;
            hash_restart();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (word %0d)", what, got, want, words_seen);
        mismatches++;
    endtask

    // Offer one beat and hold it until taken; then either carry on in the
    // burst or drop valid for a random gap
    task automatic send_beat(input logic [7:0] b, input logic [1:0] m,
                             input bit typed, input logic [255:0] typed_digest);
        bit done;
        logic [7:0][31:0] dig;
        digest_beat_t beat;
        s_valid <= 1'b1;
        s_message_byte <= b;
        s_mode <= m;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        hash_absorb(b, m, done, dig);
        if (done) begin
            for (int i = 0; i < 8; i++) begin
                beat.word  = typed ? typed_digest[255 - 32*i -: 32] : dig[i];
                beat.index = 3'(i);
                beat.last  = (i == 7);
                digest_beats_q.push_back(beat);
            end
        end
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and hold off until every digest word has come back
    task automatic wait_for_digests();
        s_valid <= 1'b0;
        while (digest_beats_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: check each digest beat against the oldest expectation, then
    // pick m_ready for the next edge. The ready style is redrawn at random;
    // once, a long hold-off lets the block back up into its input.
    int  ready_style = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    digest_beat_t want_beat;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_beats_q.size() == 0) begin
                report_mismatch("unexpected beat", m_digest_word, 32'd0);
            end else begin
                want_beat = digest_beats_q.pop_front();
                if (m_digest_word !== want_beat.word)
                    report_mismatch("digest_word", m_digest_word, want_beat.word);
                if (m_word_index !== want_beat.index)
                    report_mismatch("word_index", 32'(m_word_index), 32'(want_beat.index));
                if (m_last_word !== want_beat.last)
                    report_mismatch("last_word", 32'(m_last_word), 32'(want_beat.last));
            end
            words_seen++;
        end
        if (!hold_done && words_seen >= HOLD_AT_WORDS) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (cycle_count % 32 == 0) ready_style = $urandom_range(0, 2);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ready_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Stimulus: reset, the directed table, then random messages: mostly short ones,
    // the rest at the padding boundaries (55/56 and 63/64 bytes)
    int  msg_len;
    int  msg_no;
    int  random_start;
    bit  close_with_byte;
    logic [1:0] append_mode;

    initial begin
        hash_restart();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_beat(DIRECTED[r].msg_byte, DIRECTED[r].mode, DIRECTED[r].typed,
                      DIRECTED[r].digest);
        wait_for_digests();

        random_start = items_sent;
        msg_no = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            // once, hold the sender until the pipeline has fully drained
            if (msg_no == 2) wait_for_digests();
            case ($urandom_range(0, 9))
                0:       msg_len = 55;
                1:       msg_len = 56;
                2:       msg_len = 63;
                3:       msg_len = 64;
                default: msg_len = $urandom_range(0, 12);
            endcase
            close_with_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < msg_len - int'(close_with_byte); k++) begin
                append_mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_APPEND;
                send_beat(8'($urandom_range(0, 255)), append_mode, 1'b0, 256'd0);
            end
            send_beat(8'($urandom_range(0, 255)),
                      close_with_byte ? MODE_FINISH_BYTE : MODE_FINISH, 1'b0, 256'd0);
            msg_no++;
        end

        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("sha256_byte_stream_hasher test passed");
        end else begin
            $display("sha256_byte_stream_hasher test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/shabs_pkg.sv
hw/rtl/shabs_core.sv
hw/rtl/sha256_byte_stream_hasher.sv
hw/rtl/shabs_checker.sv
dv/tb_top.sv
